### design/qbpm_pkg.sv
// Shared types, constants and helpers for the box pixel mask.
// Used by the box cell, the top level and the bench.
package qbpm_pkg;

  localparam int unsigned DEFAULT_MAX_BOXES = 8;
  localparam int unsigned CORNERS = 4;

  localparam int unsigned COORD_W  = 16;
  localparam int unsigned PIXEL_W  = 12;
  localparam int unsigned DIM_W    = 13;
  localparam int unsigned COUNT_W  = 4;
  localparam int unsigned BOX_W    = 3;
  localparam int unsigned CORNER_W = 2;
  localparam int unsigned BYTE_W   = 8;

  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W  = 13;

  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_ACTIVE_BOXES = 2'd2;

  localparam logic [DIM_W-1:0]   RESET_IMAGE_WIDTH  = 13'd640;
  localparam logic [DIM_W-1:0]   RESET_IMAGE_HEIGHT = 13'd480;
  localparam logic [COUNT_W-1:0] RESET_ACTIVE_BOXES = 4'd0;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_PIXEL = 1'b1;

  typedef struct packed {
    logic                       command;
    logic [BOX_W-1:0]           box_index;
    logic [CORNER_W-1:0]        corner_index;
    logic signed [COORD_W-1:0]  corner_x;
    logic signed [COORD_W-1:0]  corner_y;
    logic [PIXEL_W-1:0]         pixel_x;
    logic [PIXEL_W-1:0]         pixel_y;
    logic [BYTE_W-1:0]          byte_first;
    logic [BYTE_W-1:0]          byte_second;
    logic [BYTE_W-1:0]          byte_third;
  } item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_first;
    logic [BYTE_W-1:0] out_second;
    logic [BYTE_W-1:0] out_third;
    logic              covered;
  } result_t;

  typedef struct packed {
    logic [DIM_W-1:0]   image_width;
    logic [DIM_W-1:0]   image_height;
    logic [COUNT_W-1:0] active_boxes;
  } cfg_t;

  typedef struct packed {
    logic  valid;
    logic  hit;
    item_t item;
  } stage_t;

  function automatic logic [DIM_W-1:0] clamp_bound(logic signed [COORD_W-1:0] v,
                                                   logic [DIM_W-1:0] lim);
    logic signed [COORD_W:0] v_ext;
    logic signed [COORD_W:0] lim_ext;
    logic [DIM_W-1:0]        res;
    v_ext   = {v[COORD_W-1], v};
    lim_ext = {{(COORD_W+1-DIM_W){1'b0}}, lim};
    if (v_ext > lim_ext) begin
      res = lim;
    end else if (v[COORD_W-1]) begin
      res = '0;
    end else begin
      res = v[DIM_W-1:0];
    end
    return res;
  endfunction

endpackage

### design/qbpm_stream_if.sv
// Valid/ready stream channel carrying one payload struct.
// Payload types come from qbpm_pkg.
interface qbpm_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

### design/qbpm_cell.sv
// One box cell: holds the four corners and bounds of its box, tests the
// passing pixel and hands the request on to the next cell. Uses qbpm_pkg.
module qbpm_cell #(
  parameter int unsigned INDEX = 0
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            advance,
  input  qbpm_pkg::cfg_t   cfg,
  input  qbpm_pkg::stage_t stage_in,
  output qbpm_pkg::stage_t stage_out
);

  logic signed [qbpm_pkg::COORD_W-1:0] cx [qbpm_pkg::CORNERS];
  logic signed [qbpm_pkg::COORD_W-1:0] cy [qbpm_pkg::CORNERS];
  logic signed [qbpm_pkg::COORD_W-1:0] cx_next [qbpm_pkg::CORNERS];
  logic signed [qbpm_pkg::COORD_W-1:0] cy_next [qbpm_pkg::CORNERS];
  logic signed [qbpm_pkg::COORD_W-1:0] min_x, max_x, min_y, max_y;
  logic signed [qbpm_pkg::COORD_W-1:0] min_x_next, max_x_next, min_y_next, max_y_next;

  logic                         load_hit;
  logic                         active;
  logic                         covered;
  logic [qbpm_pkg::DIM_W-1:0]   sx, ex, sy, ey;
  logic [qbpm_pkg::DIM_W-1:0]   px, py;

  logic                         valid;
  logic                         hit;
  qbpm_pkg::item_t              item;

  assign load_hit = advance && stage_in.valid
                    && (stage_in.item.command == qbpm_pkg::CMD_LOAD)
                    && (32'(stage_in.item.box_index) == 32'(INDEX));

  always_comb begin
    cx_next = cx;
    cy_next = cy;
    if (load_hit) begin
      cx_next[stage_in.item.corner_index] = stage_in.item.corner_x;
      cy_next[stage_in.item.corner_index] = stage_in.item.corner_y;
    end
    min_x_next = cx_next[0];
    max_x_next = cx_next[0];
    min_y_next = cy_next[0];
    max_y_next = cy_next[0];
    for (int c = 1; c < qbpm_pkg::CORNERS; c++) begin
      if (cx_next[c] < min_x_next) min_x_next = cx_next[c];
      if (cx_next[c] > max_x_next) max_x_next = cx_next[c];
      if (cy_next[c] < min_y_next) min_y_next = cy_next[c];
      if (cy_next[c] > max_y_next) max_y_next = cy_next[c];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < qbpm_pkg::CORNERS; c++) begin
        cx[c] <= '0;
        cy[c] <= '0;
      end
      min_x <= '0;
      max_x <= '0;
      min_y <= '0;
      max_y <= '0;
    end else if (load_hit) begin
      cx    <= cx_next;
      cy    <= cy_next;
      min_x <= min_x_next;
      max_x <= max_x_next;
      min_y <= min_y_next;
      max_y <= max_y_next;
    end
  end

  assign sx = qbpm_pkg::clamp_bound(min_x, cfg.image_width);
  assign ex = qbpm_pkg::clamp_bound(max_x, cfg.image_width);
  assign sy = qbpm_pkg::clamp_bound(min_y, cfg.image_height);
  assign ey = qbpm_pkg::clamp_bound(max_y, cfg.image_height);

  assign px = {1'b0, stage_in.item.pixel_x};
  assign py = {1'b0, stage_in.item.pixel_y};

  assign active  = 32'(cfg.active_boxes) > 32'(INDEX);
  assign covered = active && (px >= sx) && (px < ex) && (py >= sy) && (py < ey);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (advance) begin
      valid <= stage_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      item <= stage_in.item;
      hit  <= stage_in.hit
              | ((stage_in.item.command == qbpm_pkg::CMD_PIXEL) & covered);
    end
  end

  assign stage_out.valid = valid;
  assign stage_out.hit   = hit;
  assign stage_out.item  = item;

endmodule

### design/quad_box_pixel_mask.sv
// A pixel result is shown once its request has passed the registered chain of box cells.
// Throughput: one request per cycle; the chain of box cells advances as one
// and stalls only while a finished result waits at the output.
// Load requests travel the chain, update their box cell and yield no result.
// Reset (rst, synchronous): all corners zero (empty boxes), width 640,
// height 480, no active boxes, chain empty.
module quad_box_pixel_mask #(
  parameter int unsigned MAX_BOXES = qbpm_pkg::DEFAULT_MAX_BOXES
) (
  input  logic                               clk,
  input  logic                               rst,
  qbpm_stream_if.sink                        item,
  qbpm_stream_if.source                      result,
  input  logic                               cfg_write,
  input  logic [qbpm_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [qbpm_pkg::CFG_DATA_W-1:0]    cfg_data
);

  qbpm_pkg::cfg_t   cfg;
  qbpm_pkg::stage_t links [MAX_BOXES+1];
  qbpm_pkg::stage_t last;
  logic             advance;
  logic             out_pending;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.image_width  <= qbpm_pkg::RESET_IMAGE_WIDTH;
      cfg.image_height <= qbpm_pkg::RESET_IMAGE_HEIGHT;
      cfg.active_boxes <= qbpm_pkg::RESET_ACTIVE_BOXES;
    end else if (cfg_write) begin
      unique case (cfg_index)
        qbpm_pkg::REG_IMAGE_WIDTH:  cfg.image_width  <= cfg_data[qbpm_pkg::DIM_W-1:0];
        qbpm_pkg::REG_IMAGE_HEIGHT: cfg.image_height <= cfg_data[qbpm_pkg::DIM_W-1:0];
        qbpm_pkg::REG_ACTIVE_BOXES: cfg.active_boxes <= cfg_data[qbpm_pkg::COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign last        = links[MAX_BOXES];
  assign out_pending = last.valid && (last.item.command == qbpm_pkg::CMD_PIXEL);
  assign advance     = !out_pending || result.ready;
  assign item.ready  = advance && !rst;

  assign links[0].valid = item.valid;
  assign links[0].hit   = 1'b0;
  assign links[0].item  = item.payload;

  for (genvar i = 0; i < MAX_BOXES; i++) begin : g_cell
    qbpm_cell #(
      .INDEX(i)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .advance  (advance),
      .cfg      (cfg),
      .stage_in (links[i]),
      .stage_out(links[i+1])
    );
  end

  assign result.valid              = out_pending;
  assign result.payload.out_first  = last.hit ? '0 : last.item.byte_first;
  assign result.payload.out_second = last.hit ? '0 : last.item.byte_second;
  assign result.payload.out_third  = last.hit ? '0 : last.item.byte_third;
  assign result.payload.covered    = last.hit;

endmodule

### verif/quad_box_pixel_mask_tb.sv
`timescale 1ns / 100ps
// Self-checking bench for quad_box_pixel_mask: corner loads and pixel requests with
// random idling on both streams, results checked in order against an in-bench model.
// Depends on qbpm_pkg, qbpm_stream_if and the quad_box_pixel_mask RTL.
module quad_box_pixel_mask_tb;

  localparam int unsigned MAX_BOXES = qbpm_pkg::DEFAULT_MAX_BOXES;
  localparam logic [qbpm_pkg::CFG_INDEX_W-1:0] NO_SUCH_REG = 2'd3;
  localparam int ITEM_TARGET   = 1400;
  localparam int SETTLE_CYCLES = 16;
  localparam int LONG_HOLD     = 250;
  localparam int IDLE_LIMIT    = 1000;

  logic                             clk;
  logic                             rst;
  logic                             cfg_write;
  logic [qbpm_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [qbpm_pkg::CFG_DATA_W-1:0]  cfg_data;

  qbpm_stream_if #(.payload_t(qbpm_pkg::item_t))   item_ch ();
  qbpm_stream_if #(.payload_t(qbpm_pkg::result_t)) result_ch ();

  quad_box_pixel_mask DUT (
    .clk       (clk),
    .rst       (rst),
    .item      (item_ch),
    .result    (result_ch),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  qbpm_pkg::item_t   mask_requests[$];
  qbpm_pkg::result_t expected_pixels[$];

  logic signed [qbpm_pkg::COORD_W-1:0] box_corner_x [MAX_BOXES*qbpm_pkg::CORNERS];
  logic signed [qbpm_pkg::COORD_W-1:0] box_corner_y [MAX_BOXES*qbpm_pkg::CORNERS];
  logic [qbpm_pkg::DIM_W-1:0]          img_width;
  logic [qbpm_pkg::DIM_W-1:0]          img_height;
  logic [qbpm_pkg::COUNT_W-1:0]        box_count;

  int error_count  = 0;
  int idle_cycles  = 0;
  int src_wait     = 0;
  int sink_wait    = 0;
  int hold_left    = 0;
  int holds_asked  = 0;
  int holds_served = 0;
  bit src_steady   = 1'b1;
  bit sink_steady  = 1'b1;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic int bound(int v, int lim);
    if (v > lim) v = lim;
    if (v < 0) v = 0;
    return v;
  endfunction

  function automatic qbpm_pkg::result_t predict_pixel(qbpm_pkg::item_t req);
    qbpm_pkg::result_t res;
    int      n, b, c, x, y, lo_x, hi_x, lo_y, hi_y;
    bit      hit;
    hit = 1'b0;
    lo_x = 0; hi_x = 0; lo_y = 0; hi_y = 0;
    n = (box_count > MAX_BOXES) ? MAX_BOXES : int'(box_count);
    for (b = 0; b < n; b++) begin
      for (c = 0; c < qbpm_pkg::CORNERS; c++) begin
        x = box_corner_x[b*qbpm_pkg::CORNERS + c];
        y = box_corner_y[b*qbpm_pkg::CORNERS + c];
        if (c == 0 || x < lo_x) lo_x = x;
        if (c == 0 || x > hi_x) hi_x = x;
        if (c == 0 || y < lo_y) lo_y = y;
        if (c == 0 || y > hi_y) hi_y = y;
      end
      if (int'(req.pixel_x) >= bound(lo_x, int'(img_width)) &&
          int'(req.pixel_x) <  bound(hi_x, int'(img_width)) &&
          int'(req.pixel_y) >= bound(lo_y, int'(img_height)) &&
          int'(req.pixel_y) <  bound(hi_y, int'(img_height)))
        hit = 1'b1;
    end
    res.covered    = hit;
    res.out_first  = hit ? '0 : req.byte_first;
    res.out_second = hit ? '0 : req.byte_second;
    res.out_third  = hit ? '0 : req.byte_third;
    return res;
  endfunction

  task automatic report_mismatch(string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    error_count++;
  endtask

  function automatic qbpm_pkg::item_t load_req(int box, int corner, int x, int y);
    qbpm_pkg::item_t r;
    logic [95:0]     noise;
    noise = {$urandom, $urandom, $urandom};
    r = noise[$bits(qbpm_pkg::item_t)-1:0];
    r.command      = qbpm_pkg::CMD_LOAD;
    r.box_index    = box[qbpm_pkg::BOX_W-1:0];
    r.corner_index = corner[qbpm_pkg::CORNER_W-1:0];
    r.corner_x     = x[qbpm_pkg::COORD_W-1:0];
    r.corner_y     = y[qbpm_pkg::COORD_W-1:0];
    return r;
  endfunction

  function automatic qbpm_pkg::item_t pixel_req(int x, int y);
    qbpm_pkg::item_t r;
    logic [95:0]     noise;
    noise = {$urandom, $urandom, $urandom};
    r = noise[$bits(qbpm_pkg::item_t)-1:0];
    r.command = qbpm_pkg::CMD_PIXEL;
    r.pixel_x = x[qbpm_pkg::PIXEL_W-1:0];
    r.pixel_y = y[qbpm_pkg::PIXEL_W-1:0];
    return r;
  endfunction

  function automatic int gap_length();
    int sel;
    sel = $urandom_range(0, 19);
    if (sel < 12) return $urandom_range(1, 3);
    if (sel < 18) return $urandom_range(4, 8);
    return $urandom_range(15, 40);
  endfunction

  function automatic int corner_coord(int dim);
    logic signed [qbpm_pkg::COORD_W-1:0] raw;
    logic [31:0]                         word;
    case ($urandom_range(0, 9))
      7: return -$urandom_range(1, 50);
      8: return dim + $urandom_range(0, 50);
      9: begin
        word = $urandom;
        raw  = word[qbpm_pkg::COORD_W-1:0];
        return raw;
      end
      default: return $urandom_range(0, dim + 1);
    endcase
  endfunction

  function automatic int image_dim();
    case ($urandom_range(0, 9))
      0: return 1;
      1: return 4096;
      2: return 0;
      3: return 8191;
      default: return $urandom_range(16, 4096);
    endcase
  endfunction

  task automatic write_reg(logic [qbpm_pkg::CFG_INDEX_W-1:0] index, int value);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value[qbpm_pkg::CFG_DATA_W-1:0];
    case (index)
      qbpm_pkg::REG_IMAGE_WIDTH:  img_width  = value[qbpm_pkg::DIM_W-1:0];
      qbpm_pkg::REG_IMAGE_HEIGHT: img_height = value[qbpm_pkg::DIM_W-1:0];
      qbpm_pkg::REG_ACTIVE_BOXES: box_count  = value[qbpm_pkg::COUNT_W-1:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (mask_requests.size() != 0 || item_ch.valid || expected_pixels.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // mostly well-formed boxes with scrambled corner order, pixels mostly aimed at box edges, stray loads
  task automatic queue_random_phase(output int added);
    int nboxes, box, b, k, c, start, n, sel, px, py;
    int lo_x, hi_x, lo_y, hi_y;
    int xs[qbpm_pkg::CORNERS];
    int ys[qbpm_pkg::CORNERS];
    int edge_x[$];
    int edge_y[$];
    added = 0;
    edge_x.push_back(int'(img_width));
    edge_y.push_back(int'(img_height));
    nboxes = $urandom_range(1, 8);
    for (b = 0; b < nboxes; b++) begin
      box  = $urandom_range(0, MAX_BOXES - 1);
      lo_x = corner_coord(int'(img_width));
      hi_x = corner_coord(int'(img_width));
      lo_y = corner_coord(int'(img_height));
      hi_y = corner_coord(int'(img_height));
      for (c = 0; c < qbpm_pkg::CORNERS; c++) begin
        if ($urandom_range(0, 5) == 0) begin
          xs[c] = corner_coord(int'(img_width));
          ys[c] = corner_coord(int'(img_height));
        end else begin
          xs[c] = (c & 1) ? hi_x : lo_x;
          ys[c] = (c & 2) ? hi_y : lo_y;
        end
      end
      start = $urandom_range(0, qbpm_pkg::CORNERS - 1);
      for (k = 0; k < qbpm_pkg::CORNERS; k++) begin
        c = (start + k) % qbpm_pkg::CORNERS;
        mask_requests.push_back(load_req(box, c, xs[c], ys[c]));
        edge_x.push_back(xs[c]);
        edge_y.push_back(ys[c]);
        added++;
      end
    end
    n = $urandom_range(60, 110);
    for (k = 0; k < n; k++) begin
      sel = $urandom_range(0, 9);
      if (sel < 6) begin
        px = edge_x[$urandom_range(0, edge_x.size() - 1)] + $urandom_range(0, 2) - 1;
        py = edge_y[$urandom_range(0, edge_y.size() - 1)] + $urandom_range(0, 2) - 1;
      end else if (sel < 9) begin
        px = $urandom_range(0, (img_width > 4095) ? 4095 : int'(img_width));
        py = $urandom_range(0, (img_height > 4095) ? 4095 : int'(img_height));
      end else begin
        px = $urandom_range(0, 4095);
        py = $urandom_range(0, 4095);
      end
      if (px < 0 || px > 4095) px = $urandom_range(0, 4095);
      if (py < 0 || py > 4095) py = $urandom_range(0, 4095);
      mask_requests.push_back(pixel_req(px, py));
      added++;
      if ($urandom_range(0, 14) == 0) begin
        mask_requests.push_back(load_req($urandom_range(0, MAX_BOXES - 1),
                                         $urandom_range(0, qbpm_pkg::CORNERS - 1),
                                         $urandom_range(0, 65535), $urandom_range(0, 65535)));
        added++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      item_ch.valid   <= 1'b0;
      item_ch.payload <= '0;
      src_wait = 0;
    end else if (!item_ch.valid || item_ch.ready) begin
      if (src_wait > 0 || mask_requests.size() == 0) begin
        if (src_wait > 0) src_wait--;
        item_ch.valid <= 1'b0;
      end else begin
        item_ch.valid   <= 1'b1;
        item_ch.payload <= mask_requests.pop_front();
        if (!src_steady && $urandom_range(0, 2) == 0) src_wait = gap_length();
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else if (holds_served < holds_asked) begin
      holds_served++;
      hold_left = LONG_HOLD - 1;
      result_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      result_ch.ready <= 1'b0;
    end else if (sink_wait > 0) begin
      sink_wait--;
      result_ch.ready <= 1'b0;
    end else begin
      result_ch.ready <= 1'b1;
      if (!sink_steady && $urandom_range(0, 2) == 0) sink_wait = gap_length();
    end
  end

  always @(posedge clk) begin
    qbpm_pkg::item_t   req;
    qbpm_pkg::result_t got;
    qbpm_pkg::result_t want;
    if (!rst) begin
      if (result_ch.valid && result_ch.ready) begin
        got = result_ch.payload;
        if (expected_pixels.size() == 0) begin
          report_mismatch($sformatf("result %h with no pixel request pending", got));
        end else begin
          want = expected_pixels.pop_front();
          if (got.out_first !== want.out_first)
            report_mismatch($sformatf("out_first got %0d want %0d", got.out_first, want.out_first));
          if (got.out_second !== want.out_second)
            report_mismatch($sformatf("out_second got %0d want %0d", got.out_second,
                                      want.out_second));
          if (got.out_third !== want.out_third)
            report_mismatch($sformatf("out_third got %0d want %0d", got.out_third, want.out_third));
          if (got.covered !== want.covered)
            report_mismatch($sformatf("covered got %b want %b", got.covered, want.covered));
        end
      end
      if (item_ch.valid && item_ch.ready) begin
        req = item_ch.payload;
        if (req.command == qbpm_pkg::CMD_PIXEL) begin
          expected_pixels.push_back(predict_pixel(req));
        end else if (req.box_index < MAX_BOXES) begin
          box_corner_x[int'(req.box_index)*qbpm_pkg::CORNERS + int'(req.corner_index)] =
            req.corner_x;
          box_corner_y[int'(req.box_index)*qbpm_pkg::CORNERS + int'(req.corner_index)] =
            req.corner_y;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("[%0t] no request or result moved for %0d cycles", $realtime, IDLE_LIMIT);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin
    qbpm_pkg::item_t r;
    int    total, added, phase_num, w, h, a;
    rst             = 1'b1;
    cfg_write       = 1'b0;
    cfg_index       = '0;
    cfg_data        = '0;
    img_width       = qbpm_pkg::RESET_IMAGE_WIDTH;
    img_height      = qbpm_pkg::RESET_IMAGE_HEIGHT;
    box_count       = qbpm_pkg::RESET_ACTIVE_BOXES;
    foreach (box_corner_x[i]) begin
      box_corner_x[i] = '0;
      box_corner_y[i] = '0;
    end
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    r = pixel_req(0, 0);
    r.byte_first = 8'hFF; r.byte_second = 8'hFF; r.byte_third = 8'hFF;
    mask_requests.push_back(r);
    mask_requests.push_back(pixel_req(4095, 4095));
    wait_idle();

    write_reg(qbpm_pkg::REG_ACTIVE_BOXES, 1);
    mask_requests.push_back(pixel_req(0, 0));
    mask_requests.push_back(load_req(0, 0, 10, 20));
    mask_requests.push_back(load_req(0, 1, -32768, 20));
    mask_requests.push_back(load_req(0, 2, 10, 32767));
    mask_requests.push_back(load_req(0, 3, -32768, 32767));
    r = pixel_req(0, 20);
    r.byte_first = 8'hFF; r.byte_second = 8'hFF; r.byte_third = 8'hFF;
    mask_requests.push_back(r);
    mask_requests.push_back(pixel_req(9, 479));
    mask_requests.push_back(pixel_req(10, 20));
    mask_requests.push_back(pixel_req(0, 19));
    mask_requests.push_back(pixel_req(0, 480));
    mask_requests.push_back(pixel_req(4095, 4095));
    r = pixel_req(5, 100);
    r.byte_first = 8'h00; r.byte_second = 8'h00; r.byte_third = 8'h00;
    mask_requests.push_back(r);
    mask_requests.push_back(load_req(7, 3, 200, 200));
    mask_requests.push_back(load_req(7, 2, 100, 200));
    mask_requests.push_back(load_req(7, 1, 200, 100));
    mask_requests.push_back(load_req(7, 0, 100, 100));
    mask_requests.push_back(pixel_req(150, 150));
    wait_idle();

    // active count above the box limit, with junk in the upper data bits
    write_reg(qbpm_pkg::REG_ACTIVE_BOXES, 13'h1FFF);
    write_reg(NO_SUCH_REG, 13'h0AAA);
    mask_requests.push_back(pixel_req(150, 150));
    mask_requests.push_back(pixel_req(199, 199));
    mask_requests.push_back(pixel_req(200, 150));
    wait_idle();

    write_reg(qbpm_pkg::REG_IMAGE_WIDTH, 0);
    mask_requests.push_back(pixel_req(0, 20));
    mask_requests.push_back(pixel_req(150, 150));
    wait_idle();

    total = 0;
    phase_num = 0;
    while (total < ITEM_TARGET) begin
      case (phase_num)
        0: begin w = 4096; h = 4096; a = 8; end
        1: begin w = 1; h = 1; a = 15; end
        2: begin w = 640; h = 480; a = 0; end
        default: begin
          w = image_dim();
          h = image_dim();
          a = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 15) : $urandom_range(4, 8);
        end
      endcase
      write_reg(qbpm_pkg::REG_IMAGE_WIDTH, w);
      write_reg(qbpm_pkg::REG_IMAGE_HEIGHT, h);
      write_reg(qbpm_pkg::REG_ACTIVE_BOXES, a);
      if ($urandom_range(0, 2) == 0) write_reg(NO_SUCH_REG, $urandom_range(0, 8191));
      src_steady  <= (phase_num == 0) || ($urandom_range(0, 3) == 0);
      sink_steady <= (phase_num == 0) || ($urandom_range(0, 3) == 0);
      queue_random_phase(added);
      total += added;
      if (phase_num == 1 || phase_num == 6) holds_asked <= holds_asked + 1;
      wait_idle();
      phase_num++;
    end

    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

### files.f
design/qbpm_pkg.sv
design/qbpm_stream_if.sv
design/qbpm_cell.sv
design/quad_box_pixel_mask.sv
verif/quad_box_pixel_mask_tb.sv
